// ----- rtl/nstp_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// nstp_pkg - shared types for the nested section time profiler
// Beat payloads, operation and status codes, controller state and the
// command/status bundles between controller and datapath.
// ============================================================================
package nstp_pkg;

	// default sizes
	localparam int DEF_STACK_DEPTH  = 64;
	localparam int DEF_NUM_SECTIONS = 256;

	// event operation
	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_STOP  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_MISMATCH  = 2'd3
	} status_t;

	// input beat
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  section;
		logic [63:0] timestamp;
		logic        from_main_thread;
	} evt_beat_t;

	// output beat
	typedef struct packed {
		status_t     status;
		logic [63:0] total_clocks;
		logic [6:0]  depth;
	} res_beat_t;

	// controller states
	typedef enum logic [2:0] {
		S_INIT,   // totals sweep after reset
		S_IDLE,   // waiting for an event
		S_DEC,    // decode event, issue first reads
		S_STK,    // stack entry back, compute elapsed time
		S_TOT,    // total back, write credit and update stack
		S_CLR,    // totals sweep for a clear event
		S_DONE    // hand result to output register
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_item;
		logic    stk_rd;
		logic    tot_rd;
		logic    tot_rd_top;
		logic    calc;
		logic    tgt_top;
		logic    chk_match;
		logic    set_status;
		status_t status_val;
		logic    tot_wr;
		logic    push;
		logic    pop;
		logic    cnt_clr;
		logic    clr_wr;
		logic    load_res;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  main_thread;
		logic  empty;
		logic  full;
		logic  clr_last;
	} sts_t;

endpackage

// ----- rtl/nstp_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// nstp_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data that holds
// while the read enable is low.
// ============================================================================
module nstp_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [W-1:0]             wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [W-1:0]             rd_data
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/nstp_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// nstp_ctrl - profiler controller
// Sequences one event at a time through decode, stack read, totals
// read-modify-write or the clearing sweep, and owns the handshakes.
// ============================================================================
module nstp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          evt_valid,
	output logic          evt_stall,
	output logic          res_valid,
	input  logic          res_stall,
	output nstp_pkg::cmd_t cmd,
	input  nstp_pkg::sts_t sts
);

	import nstp_pkg::*;

	state_t state_q, state_d;
	logic   res_valid_q;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.status_val = ST_OK;
		case (state_q)
			S_INIT: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (evt_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DEC;
				end
			end
			S_DEC: begin
				cmd.set_status = 1'b1;
				state_d        = S_DONE;
				if (sts.main_thread) begin
					case (sts.mode)
						MODE_START: begin
							if (sts.full) begin
								cmd.status_val = ST_OVERFLOW;
							end else if (sts.empty) begin
								cmd.push = 1'b1;
							end else begin
								cmd.stk_rd = 1'b1;
								state_d    = S_STK;
							end
						end
						MODE_STOP: begin
							if (sts.empty) begin
								cmd.status_val = ST_UNDERFLOW;
							end else begin
								cmd.stk_rd = 1'b1;
								cmd.tot_rd = 1'b1;
								state_d    = S_STK;
							end
						end
						MODE_CLEAR: begin
							cmd.cnt_clr = 1'b1;
							state_d     = S_CLR;
						end
						MODE_READ: begin
							cmd.tot_rd = 1'b1;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_STK: begin
				cmd.calc = 1'b1;
				if (sts.mode == MODE_START) begin
					// credit goes to the section on top; fetch its total
					cmd.tgt_top    = 1'b1;
					cmd.tot_rd     = 1'b1;
					cmd.tot_rd_top = 1'b1;
				end else begin
					cmd.chk_match = 1'b1;
				end
				state_d = S_TOT;
			end
			S_TOT: begin
				cmd.tot_wr = 1'b1;
				if (sts.mode == MODE_START) begin
					cmd.push = 1'b1;
				end else begin
					cmd.pop = 1'b1;
				end
				state_d = S_DONE;
			end
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (!res_valid_q || !res_stall) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign evt_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

endmodule

// ----- rtl/nstp_dp.sv -----
`timescale 1ns / 1ps
// ============================================================================
// nstp_dp - profiler datapath
// Event register, stack count, stack and totals memories, elapsed time
// arithmetic, clearing sweep counter and the output register.
// ============================================================================
module nstp_dp #(
	parameter int STACK_DEPTH  = nstp_pkg::DEF_STACK_DEPTH,
	parameter int NUM_SECTIONS = nstp_pkg::DEF_NUM_SECTIONS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nstp_pkg::evt_beat_t evt,
	output nstp_pkg::res_beat_t res,
	input  nstp_pkg::cmd_t      cmd,
	output nstp_pkg::sts_t      sts
);

	import nstp_pkg::*;

	localparam int STK_AW = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int TOT_AW = $clog2(NUM_SECTIONS);
	localparam int SEC_W  = (TOT_AW > 8) ? TOT_AW : 8;
	localparam int DEP_W  = (CNT_W > 7) ? CNT_W : 7;

	// section id to totals address
	function automatic logic [TOT_AW-1:0] sec_addr(input logic [7:0] s);
		logic [SEC_W-1:0] e;
		e = SEC_W'(s);
		return e[TOT_AW-1:0];
	endfunction

	// section id has a totals entry
	function automatic logic sec_ok(input logic [7:0] s);
		return 32'(s) < NUM_SECTIONS;
	endfunction

	evt_beat_t         item_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TOT_AW-1:0] clr_cnt_q;
	logic [63:0]       elapsed_q;
	logic [7:0]        tgt_sec_q;
	status_t           status_q;
	res_beat_t         res_q;

	logic [CNT_W-1:0]  cnt_m1, cnt_m2;
	logic [DEP_W-1:0]  cnt_ext;
	logic              clr_last;

	logic [7:0]        stk_sec_rdata;
	logic [63:0]       stk_ts_rdata;
	logic [63:0]       tot_rdata;

	logic              start_wr_en;
	logic [STK_AW-1:0] start_wr_addr;
	logic              tot_wr_en;
	logic [TOT_AW-1:0] tot_wr_addr;
	logic [63:0]       tot_wr_data;
	logic [TOT_AW-1:0] tot_rd_addr;

	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign cnt_m2   = cnt_q - CNT_W'(2);
	assign cnt_ext  = DEP_W'(cnt_q);
	assign clr_last = (clr_cnt_q == TOT_AW'(NUM_SECTIONS - 1));

	// event register
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= evt;
	end

	// stack count and clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.pop) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + TOT_AW'(1);
			end
		end
	end

	// elapsed time, credit target and status
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			elapsed_q <= item_q.timestamp - stk_ts_rdata;
			tgt_sec_q <= cmd.tgt_top ? stk_sec_rdata : item_q.section;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_val;
		end else if (cmd.chk_match && (stk_sec_rdata != item_q.section)) begin
			status_q <= ST_MISMATCH;
		end
	end

	// stack memories: top read at count-1, push at count, parent restart at count-2
	assign start_wr_en   = cmd.push || (cmd.pop && (cnt_q > CNT_W'(1)));
	assign start_wr_addr = cmd.push ? cnt_q[STK_AW-1:0] : cnt_m2[STK_AW-1:0];

	nstp_ram #(.W(8), .DEPTH(STACK_DEPTH)) u_stk_sec (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (cnt_q[STK_AW-1:0]),
		.wr_data (item_q.section),
		.rd_en   (cmd.stk_rd),
		.rd_addr (cnt_m1[STK_AW-1:0]),
		.rd_data (stk_sec_rdata)
	);

	nstp_ram #(.W(64), .DEPTH(STACK_DEPTH)) u_stk_ts (
		.clk     (clk),
		.wr_en   (start_wr_en),
		.wr_addr (start_wr_addr),
		.wr_data (item_q.timestamp),
		.rd_en   (cmd.stk_rd),
		.rd_addr (cnt_m1[STK_AW-1:0]),
		.rd_data (stk_ts_rdata)
	);

	// totals memory: credit write or zero sweep
	assign tot_rd_addr = cmd.tot_rd_top ? sec_addr(stk_sec_rdata) : sec_addr(item_q.section);
	assign tot_wr_en   = cmd.clr_wr || (cmd.tot_wr && sec_ok(tgt_sec_q));
	assign tot_wr_addr = cmd.clr_wr ? clr_cnt_q : sec_addr(tgt_sec_q);
	assign tot_wr_data = cmd.clr_wr ? 64'd0 : tot_rdata + elapsed_q;

	nstp_ram #(.W(64), .DEPTH(NUM_SECTIONS)) u_tot (
		.clk     (clk),
		.wr_en   (tot_wr_en),
		.wr_addr (tot_wr_addr),
		.wr_data (tot_wr_data),
		.rd_en   (cmd.tot_rd),
		.rd_addr (tot_rd_addr),
		.rd_data (tot_rdata)
	);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_q.status <= status_q;
			res_q.total_clocks <= (item_q.from_main_thread && (item_q.mode == MODE_READ) &&
				sec_ok(item_q.section)) ? tot_rdata : 64'd0;
			res_q.depth <= cnt_ext[6:0];
		end
	end

	assign res = res_q;

	assign sts.mode        = item_q.mode;
	assign sts.main_thread = item_q.from_main_thread;
	assign sts.empty       = (cnt_q == '0);
	assign sts.full        = (cnt_q == CNT_W'(STACK_DEPTH));
	assign sts.clr_last    = clr_last;

endmodule

// ----- rtl/nested_section_time_profiler.sv -----
`timescale 1ns / 1ps
// ============================================================================
// nested_section_time_profiler - exclusive-time profiler for nested sections
// Stack of open sections with start stamps and a table of per-section
// totals; start/stop credit elapsed clocks, clear zeroes, read returns one.
// ============================================================================
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------
//  evt     | in  | evt_valid / evt_stall  | mode, section, timestamp, thread
//  res     | out | res_valid / res_stall  | status, total_clocks, depth
//
// One event at a time. Ignored, overflow, underflow, read and a start on an
// empty stack go from decode straight to the result; start and stop with a
// credit add a stack read, a totals read and a totals write; clear adds a
// sweep over all NUM_SECTIONS totals.
// After reset the totals memory is swept to zero with evt_stall high.
// A result waits in the output register; the next event is accepted
// meanwhile and its result is held back until res is free.
//
module nested_section_time_profiler #(
	parameter int STACK_DEPTH  = nstp_pkg::DEF_STACK_DEPTH,
	parameter int NUM_SECTIONS = nstp_pkg::DEF_NUM_SECTIONS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_stall,
	input  nstp_pkg::evt_beat_t evt,
	output logic                res_valid,
	input  logic                res_stall,
	output nstp_pkg::res_beat_t res
);

	import nstp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller
	nstp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath
	nstp_dp #(
		.STACK_DEPTH  (STACK_DEPTH),
		.NUM_SECTIONS (NUM_SECTIONS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
